// ===== rtl/lfu_replacement_policy_macros.svh =====
// ---------------------------------------------------------------------------
// LFU replacement policy assertion macros
// Wrappers for concurrent checks; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef LFU_REPLACEMENT_POLICY_MACROS_SVH
`define LFU_REPLACEMENT_POLICY_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LFURP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LFURP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFURP_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define LFURP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/lfurp_pkg.sv =====
// ---------------------------------------------------------------------------
// LFU replacement policy package
// Request field widths and operation codes.
// ---------------------------------------------------------------------------
package lfurp_pkg;

  localparam int OP_W   = 2;
  localparam int SET_FW = 6;
  localparam int WAY_FW = 3;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ACCESS = 2'd0;
  localparam op_t OP_EVICT  = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;

endpackage

// ===== rtl/lfu_replacement_policy.sv =====
// ---------------------------------------------------------------------------
// LFU replacement policy
// Per-way saturating use counters in a row-per-set memory; victim search.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. After reset the
// block is busy while it clears the counter memory one set per cycle. An
// access or eviction reads the set's row from the counter memory, then
// writes the modified row back. A victim query reads the row, compares
// one way per cycle against the running minimum, and shows victim_way
// with done high for one cycle as busy drops, so the next request can be
// taken in that same cycle. A query for a set out of range answers way 0
// with done in the next cycle.
// The receiver cannot stall; done is a one-cycle strobe.
`include "lfu_replacement_policy_macros.svh"

module lfu_replacement_policy #(
  parameter int SETS       = 64,
  parameter int WAYS       = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  lfurp_pkg::op_t              operation,
  input  logic [lfurp_pkg::SET_FW-1:0] set_index,
  input  logic [lfurp_pkg::WAY_FW-1:0] way,
  output logic                        done,
  output logic [lfurp_pkg::WAY_FW-1:0] victim_way
);

  localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  typedef logic [WAYS-1:0][COUNT_BITS-1:0] row_t;

  row_t mem [SETS];
  row_t rd_data;
  row_t wr_row;

  logic [1:0]            state;
  logic [SET_AW-1:0]     clr_addr;
  logic [IDX_W-1:0]      scan_idx;
  lfurp_pkg::op_t        op_q;
  logic [SET_AW-1:0]     set_q;
  logic [IDX_W-1:0]      way_q;
  logic [COUNT_BITS-1:0] best_count;
  logic [IDX_W-1:0]      best_way;

  logic                  accept;
  logic                  set_ok;
  logic                  way_ok;
  logic                  upd_req;
  logic                  mem_we;
  logic [SET_AW-1:0]     mem_wa;
  row_t                  mem_wd;
  logic                  mem_re;
  logic [COUNT_BITS-1:0] cur_count;
  logic                  take;
  logic [IDX_W-1:0]      win_way;
  logic                  scan_last;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign set_ok  = (32'(set_index) < SETS);
  assign way_ok  = (32'(way) < WAYS);
  assign upd_req = set_ok && way_ok &&
                   ((operation == lfurp_pkg::OP_ACCESS) ||
                    (operation == lfurp_pkg::OP_EVICT));

  // read-modify-write of one counter; saturates at all ones
  always_comb begin
    wr_row = rd_data;
    if (op_q == lfurp_pkg::OP_ACCESS) begin
      if (rd_data[way_q] != '1) begin
        wr_row[way_q] = rd_data[way_q] + COUNT_BITS'(1);
      end
    end else begin
      wr_row[way_q] = '0;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = set_q;
    mem_wd = wr_row;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else if (state == S_UPD) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re = accept && set_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[SET_AW'(set_index)];
    end
  end

  // victim search: one way per cycle, strict less-than keeps the lowest way
  assign cur_count = rd_data[scan_idx];
  assign take      = (scan_idx == '0) || (cur_count < best_count);
  assign win_way   = take ? scan_idx : best_way;
  assign scan_last = (32'(scan_idx) == WAYS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      scan_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (32'(clr_addr) == SETS - 1) begin
            state <= S_IDLE;
          end
          clr_addr <= clr_addr + SET_AW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            if (upd_req) begin
              state <= S_UPD;
            end else if (operation == lfurp_pkg::OP_QUERY) begin
              if (set_ok) begin
                state    <= S_SCAN;
                scan_idx <= '0;
              end else begin
                done <= 1'b1;
              end
            end
          end
        end
        S_UPD: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= operation;
      set_q      <= SET_AW'(set_index);
      way_q      <= IDX_W'(way);
      victim_way <= '0;
    end
    if (state == S_SCAN) begin
      if (take) begin
        best_count <= cur_count;
        best_way   <= scan_idx;
      end
      if (scan_last) begin
        victim_way <= lfurp_pkg::WAY_FW'(win_way);
      end
    end
  end

  `LFURP_ASSERT_IMPLY(a_done_idle, clk, rst, done, state == S_IDLE, "result strobe outside idle")
  `LFURP_ASSERT_IMPLY(a_we_state, clk, rst, mem_we, (state == S_CLEAR) || (state == S_UPD), "counter write in wrong state")
  `LFURP_ASSERT_NEXT(a_upd_follows, clk, rst, accept && upd_req, state == S_UPD, "update request did not reach write back")
  `LFURP_ASSERT_IMPLY(a_scan_range, clk, rst, state == S_SCAN, 32'(scan_idx) < WAYS, "scan index past last way")

endmodule
